FILE: hw/rtl/jsu_pkg.sv
package jsu_pkg;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_UNI   = 2'd2;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF_CONT  = 8'h80;
  localparam logic [15:0] UTF_ONE_MAX = 16'h0080;
  localparam logic [15:0] UTF_TWO_MAX = 16'h0800;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // decoded bytes of one input item; last applies to the final valid byte
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            last;
  } res_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [1:0]      pcnt;
    logic [2:0][7:0] pend;
  } state_t;

  function automatic logic [7:0] simple_escape(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      CH_B:    r = 8'h08;
      CH_F:    r = 8'h0C;
      CH_N:    r = 8'h0A;
      CH_R:    r = 8'h0D;
      CH_T:    r = 8'h09;
      default: r = b;
    endcase
    return r;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic res_t utf8_encode(input logic [15:0] code);
    res_t r;
    r = '0;
    if (code < UTF_ONE_MAX) begin
      r.bytes[0] = code[7:0];
      r.count    = 3'd1;
    end else if (code < UTF_TWO_MAX) begin
      r.bytes[0] = UTF_LEAD2 | {3'b000, code[10:6]};
      r.bytes[1] = UTF_CONT | {2'b00, code[5:0]};
      r.count    = 3'd2;
    end else begin
      r.bytes[0] = UTF_LEAD3 | {4'b0000, code[15:12]};
      r.bytes[1] = UTF_CONT | {2'b00, code[11:6]};
      r.bytes[2] = UTF_CONT | {2'b00, code[5:0]};
      r.count    = 3'd3;
    end
    return r;
  endfunction

  // plain-text decode of a cut-short unicode escape, n bytes in tbuf
  function automatic res_t decode_tail(input logic [3:0][7:0] tbuf, input logic [2:0] n);
    res_t            r;
    logic            skip;
    logic [4:0][7:0] ext;
    r    = '0;
    skip = 1'b0;
    ext  = {8'h00, tbuf};
    for (int p = 0; p < 4; p++) begin
      if (skip) begin
        skip = 1'b0;
      end else if (3'(p) < n) begin
        if (ext[p] == CH_BSLASH && 3'(p + 1) < n) begin
          // backslash-u is too short here: drop the backslash only
          if (ext[p+1] != CH_U) begin
            r.bytes[r.count[1:0]] = simple_escape(ext[p+1]);
            r.count = r.count + 3'd1;
            skip = 1'b1;
          end
        end else begin
          r.bytes[r.count[1:0]] = ext[p];
          r.count = r.count + 3'd1;
        end
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/jsu_decode.sv
module jsu_decode (
  input  jsu_pkg::in_item_t item,
  input  jsu_pkg::state_t   st,
  output jsu_pkg::state_t   st_next,
  output jsu_pkg::res_t     res
);

  logic [7:0]      b;
  logic            last;
  logic [3:0][7:0] tail;
  logic [3:0][7:0] chars;
  logic [15:0]     code;
  logic            stop;
  logic [4:0]      h;

  assign b    = item.in_byte;
  assign last = item.in_last;

  always_comb begin
    st_next = st;
    res     = '0;
    tail    = '0;
    chars   = {b, st.pend[2], st.pend[1], st.pend[0]};
    code    = '0;
    stop    = 1'b0;
    h       = '0;
    case (st.mode)
      jsu_pkg::MODE_ESC: begin
        if (b == jsu_pkg::CH_U && !last) begin
          st_next.mode = jsu_pkg::MODE_UNI;
          st_next.pcnt = 2'd0;
        end else begin
          res.bytes[0] = jsu_pkg::simple_escape(b);
          res.count    = 3'd1;
          st_next.mode = jsu_pkg::MODE_PLAIN;
        end
      end
      jsu_pkg::MODE_UNI: begin
        if (st.pcnt != 2'd3 && !last) begin
          st_next.pend[st.pcnt] = b;
          st_next.pcnt = st.pcnt + 2'd1;
        end else begin
          if (st.pcnt != 2'd3) begin
            tail[0] = jsu_pkg::CH_U;
            for (int j = 0; j < 3; j++) begin
              if (2'(j) < st.pcnt) begin
                tail[j+1] = st.pend[j];
              end else if (2'(j) == st.pcnt) begin
                tail[j+1] = b;
              end
            end
            res = jsu_pkg::decode_tail(tail, {1'b0, st.pcnt} + 3'd2);
          end else begin
            // value from the leading hex prefix; all four chars consumed
            for (int j = 0; j < 4; j++) begin
              h = jsu_pkg::hex_value(chars[j]);
              if (!stop) begin
                if (h[4]) begin
                  code = {code[11:0], h[3:0]};
                end else begin
                  stop = 1'b1;
                end
              end
            end
            res = jsu_pkg::utf8_encode(code);
          end
          st_next.mode = jsu_pkg::MODE_PLAIN;
          st_next.pcnt = 2'd0;
        end
      end
      default: begin
        st_next.mode = jsu_pkg::MODE_PLAIN;
        if (b == jsu_pkg::CH_BSLASH && !last) begin
          st_next.mode = jsu_pkg::MODE_ESC;
        end else begin
          res.bytes[0] = b;
          res.count    = 3'd1;
        end
      end
    endcase
    if (last) begin
      st_next.mode = jsu_pkg::MODE_PLAIN;
      st_next.pcnt = 2'd0;
      res.last     = (res.count != 3'd0);
    end
  end

endmodule

FILE: hw/rtl/json_string_unescape_unit.sv
// JSON string unescaper.
// raw channel (raw_valid/raw_ready/raw): one escaped string byte per item, with
// in_last on the final byte of the string.
// dec channel (dec_valid/dec_ready/dec): unescaped bytes, UTF-8 for \uXXXX,
// out_last on the final decoded byte of the string.
// Each raw item is decoded in the cycle it is accepted and its 0 to 4 result
// bytes are loaded into a result buffer; the first byte appears on dec in the
// cycle after acceptance. The buffer drains one byte per cycle while dec_ready
// is high, and bytes that give a single result (the common case) then flow at
// one item per cycle. raw_ready is held high while the buffer is empty or its
// last byte leaves this cycle, so a new item waits until the last byte of the
// earlier item leaves. Items that give no result (a backslash, collected \u
// characters) leave the buffer empty. A stall on dec holds the buffer and its
// current byte stable and keeps raw_ready low while any byte is waiting.
// Reset (rst, synchronous) empties the buffer and returns to plain-text mode.
module json_string_unescape_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              raw_valid,
  output logic              raw_ready,
  input  jsu_pkg::in_item_t raw,
  output logic              dec_valid,
  input  logic              dec_ready,
  output jsu_pkg::out_item_t dec
);

  jsu_pkg::state_t st;
  jsu_pkg::state_t st_next;
  jsu_pkg::res_t   dres;

  logic [1:0]      mode;
  logic [1:0]      pcnt;
  logic [2:0][7:0] pend;

  logic [3:0][7:0] res_bytes;
  logic [2:0]      res_left;
  logic [1:0]      res_pos;
  logic            res_last;

  logic accept;
  logic take;

  assign st = '{mode: mode, pcnt: pcnt, pend: pend};

  jsu_decode u_decode (
    .item    (raw),
    .st      (st),
    .st_next (st_next),
    .res     (dres)
  );

  assign take      = dec_valid && dec_ready;
  assign raw_ready = (res_left == 3'd0) || (res_left == 3'd1 && dec_ready);
  assign accept    = raw_valid && raw_ready;

  assign dec_valid    = (res_left != 3'd0);
  assign dec.out_byte = res_bytes[res_pos];
  assign dec.out_last = res_last && (res_left == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= jsu_pkg::MODE_PLAIN;
      pcnt     <= 2'd0;
      res_left <= 3'd0;
      res_pos  <= 2'd0;
      res_last <= 1'b0;
    end else if (accept) begin
      mode     <= st_next.mode;
      pcnt     <= st_next.pcnt;
      res_left <= dres.count;
      res_pos  <= 2'd0;
      res_last <= dres.last;
    end else if (take) begin
      res_left <= res_left - 3'd1;
      res_pos  <= res_pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend      <= st_next.pend;
      res_bytes <= dres.bytes;
    end
  end

endmodule

FILE: tb/jsu_decode_checker.sv
`timescale 1ns / 1ps

module jsu_decode_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               raw_valid,
  input  logic               raw_ready,
  input  jsu_pkg::in_item_t  raw,
  input  logic               dec_valid,
  input  logic               dec_ready,
  input  jsu_pkg::out_item_t dec,
  output int                 mismatches,
  output int                 outstanding
);

  // scanner state as the block should hold it
  logic [1:0] scan_st;
  logic [1:0] uni_cnt;
  logic [7:0] uni_chars [3];

  jsu_pkg::out_item_t decoded_q [$];
  jsu_pkg::out_item_t want;
  int                 err_cnt = 0;

  function automatic logic [7:0] escaped_byte(input logic [7:0] b);
    case (b)
      jsu_pkg::CH_B: return 8'h08;
      jsu_pkg::CH_F: return 8'h0C;
      jsu_pkg::CH_N: return 8'h0A;
      jsu_pkg::CH_R: return 8'h0D;
      jsu_pkg::CH_T: return 8'h09;
      default:       return b;
    endcase
  endfunction

  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'(8'h30);
    if (b >= "a" && b <= "f") return int'(b) - int'(8'h61) + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'(8'h41) + 10;
    return -1;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] exp_v,
                                 input logic [7:0] got_v);
    $display("%0t: decode error, %s: expected %02h got %02h", $time, what, exp_v, got_v);
    err_cnt++;
  endtask

  // works out the decoded bytes that one raw item releases
  task automatic decode_raw_item(input logic [7:0] b, input logic last);
    logic [7:0]         res [4];
    logic [7:0]         tail [5];
    logic [7:0]         chars [4];
    logic [15:0]        code;
    jsu_pkg::out_item_t item;
    bit                 in_prefix;
    int                 n, tn, i, h;
    n = 0;
    case (scan_st)
      jsu_pkg::MODE_ESC: begin
        if (b == jsu_pkg::CH_U && !last) begin
          scan_st = jsu_pkg::MODE_UNI;
          uni_cnt = '0;
        end else begin
          res[n] = escaped_byte(b);
          n++;
          scan_st = jsu_pkg::MODE_PLAIN;
        end
      end
      jsu_pkg::MODE_UNI: begin
        if (uni_cnt < 2'd3 && !last) begin
          uni_chars[uni_cnt] = b;
          uni_cnt = uni_cnt + 2'd1;
        end else begin
          if (uni_cnt < 2'd3) begin
            // cut short: drop the backslash, rescan u and the rest as text
            tail[0] = jsu_pkg::CH_U;
            for (i = 0; i < int'(uni_cnt); i++) tail[i + 1] = uni_chars[i];
            tail[int'(uni_cnt) + 1] = b;
            tn = int'(uni_cnt) + 2;
            i = 0;
            while (i < tn) begin
              if (tail[i] == jsu_pkg::CH_BSLASH && i + 1 < tn) begin
                if (tail[i + 1] == jsu_pkg::CH_U) begin
                  i = i + 1;
                end else begin
                  res[n] = escaped_byte(tail[i + 1]);
                  n++;
                  i = i + 2;
                end
              end else begin
                res[n] = tail[i];
                n++;
                i = i + 1;
              end
            end
          end else begin
            chars[0] = uni_chars[0];
            chars[1] = uni_chars[1];
            chars[2] = uni_chars[2];
            chars[3] = b;
            code = '0;
            in_prefix = 1'b1;
            for (i = 0; i < 4; i++) begin
              h = hex_nibble(chars[i]);
              if (in_prefix && h >= 0) code = {code[11:0], 4'(h)};
              else in_prefix = 1'b0;
            end
            if (code < jsu_pkg::UTF_ONE_MAX) begin
              res[0] = code[7:0];
              n = 1;
            end else if (code < jsu_pkg::UTF_TWO_MAX) begin
              res[0] = jsu_pkg::UTF_LEAD2 | {3'b000, code[10:6]};
              res[1] = jsu_pkg::UTF_CONT | {2'b00, code[5:0]};
              n = 2;
            end else begin
              res[0] = jsu_pkg::UTF_LEAD3 | {4'b0000, code[15:12]};
              res[1] = jsu_pkg::UTF_CONT | {2'b00, code[11:6]};
              res[2] = jsu_pkg::UTF_CONT | {2'b00, code[5:0]};
              n = 3;
            end
          end
          scan_st = jsu_pkg::MODE_PLAIN;
          uni_cnt = '0;
        end
      end
      default: begin
        scan_st = jsu_pkg::MODE_PLAIN;
        if (b == jsu_pkg::CH_BSLASH && !last) begin
          scan_st = jsu_pkg::MODE_ESC;
        end else begin
          res[n] = b;
          n++;
        end
      end
    endcase
    if (last) begin
      scan_st = jsu_pkg::MODE_PLAIN;
      uni_cnt = '0;
    end
    for (i = 0; i < n; i++) begin
      item.out_byte = res[i];
      item.out_last = last && (i == n - 1);
      decoded_q = {decoded_q, item};
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scan_st = jsu_pkg::MODE_PLAIN;
      uni_cnt = '0;
      decoded_q.delete();
    end else begin
      if (dec_valid && dec_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("item with nothing pending", 8'h00, dec.out_byte);
        end else begin
          want = decoded_q.pop_front();
          if (dec.out_byte !== want.out_byte)
            report_mismatch("out_byte", want.out_byte, dec.out_byte);
          if (dec.out_last !== want.out_last)
            report_mismatch("out_last", 8'(want.out_last), 8'(dec.out_last));
        end
      end
      if (raw_valid && raw_ready) decode_raw_item(raw.in_byte, raw.in_last);
    end
    outstanding <= decoded_q.size();
    mismatches  <= err_cnt;
  end

endmodule

FILE: tb/tb_json_string_unescape_unit.sv
`timescale 1ns / 1ps

module tb_json_string_unescape_unit;

  logic               clk;
  logic               rst;
  logic               raw_valid;
  logic               raw_ready;
  jsu_pkg::in_item_t  raw;
  logic               dec_valid;
  logic               dec_ready;
  jsu_pkg::out_item_t dec;

  int mismatches;
  int outstanding;
  int dec_seen;
  int raw_sent;
  bit hold_done;

  json_string_unescape_unit dut (
    .clk       (clk),
    .rst       (rst),
    .raw_valid (raw_valid),
    .raw_ready (raw_ready),
    .raw       (raw),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec)
  );

  jsu_decode_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .raw_valid   (raw_valid),
    .raw_ready   (raw_ready),
    .raw         (raw),
    .dec_valid   (dec_valid),
    .dec_ready   (dec_ready),
    .dec         (dec),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && dec_valid && dec_ready) dec_seen <= dec_seen + 1;
  end

  // offers one raw item, after an optional idle gap, and waits for acceptance
  task automatic send_raw(input logic [7:0] b, input logic last);
    int r;
    r = $urandom_range(0, 99);
    if (r >= 60) begin
      raw_valid <= 1'b0;
      if (r < 92) repeat ($urandom_range(1, 3)) @(posedge clk);
      else repeat ($urandom_range(10, 40)) @(posedge clk);
    end
    raw_valid <= 1'b1;
    raw.in_byte <= b;
    raw.in_last <= last;
    do @(posedge clk); while (!raw_ready);
    raw_sent++;
  endtask

  task automatic send_string(input logic [7:0] s [$]);
    for (int i = 0; i < s.size(); i++) send_raw(s[i], i == s.size() - 1);
  endtask

  // stop offering and let every pending decoded byte come out
  task automatic drain;
    raw_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // sink side
  initial begin
    int r;
    dec_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && dec_seen >= 60) begin
        // long hold-off so the block backs up into the raw side
        dec_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          dec_ready <= 1'b1;
          repeat ($urandom_range(20, 60)) @(posedge clk);
        end else if (r < 70) begin
          dec_ready <= 1'b1;
          @(posedge clk);
        end else if (r < 95) begin
          dec_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          dec_ready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // source side
  initial begin
    logic [7:0] s [$];
    int         len, kind, random_sent;
    bit         paused;
    rst       = 1'b1;
    raw_valid = 1'b0;
    raw       = '0;
    raw_sent  = 0;
    paused    = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed strings
    send_string('{8'h00, 8'hFF});
    send_string('{jsu_pkg::CH_BSLASH, jsu_pkg::CH_N});
    send_string('{jsu_pkg::CH_BSLASH, jsu_pkg::CH_U, "F", "F", "F", "F"});
    send_string('{jsu_pkg::CH_BSLASH, jsu_pkg::CH_U, "0", "0", "e", "9"});
    send_string('{jsu_pkg::CH_BSLASH, jsu_pkg::CH_U, "z"});
    send_string('{jsu_pkg::CH_BSLASH});
    send_string('{jsu_pkg::CH_BSLASH, jsu_pkg::CH_U});
    send_string('{jsu_pkg::CH_BSLASH, jsu_pkg::CH_U, jsu_pkg::CH_BSLASH, jsu_pkg::CH_N});
    drain();

    random_sent = raw_sent;
    while (raw_sent - random_sent < 500) begin
      s.delete();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 12);
      while (s.size() < len) begin
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          s = {s, 8'($urandom_range(0, 255))};
        end else if (kind < 6) begin
          s = {s, jsu_pkg::CH_BSLASH};
          case ($urandom_range(0, 8))
            0: s = {s, 8'h22};
            1: s = {s, jsu_pkg::CH_BSLASH};
            2: s = {s, 8'h2F};
            3: s = {s, jsu_pkg::CH_B};
            4: s = {s, jsu_pkg::CH_F};
            5: s = {s, jsu_pkg::CH_N};
            6: s = {s, jsu_pkg::CH_R};
            7: s = {s, jsu_pkg::CH_T};
            default: s = {s, 8'($urandom_range(0, 255))};
          endcase
        end else if (kind < 9) begin
          s = {s, jsu_pkg::CH_BSLASH};
          s = {s, jsu_pkg::CH_U};
          for (int d = 0; d < 4; d++) begin
            int v;
            v = $urandom_range(0, 15);
            // leading zeros often, so all three encoded lengths show up
            if (d < 2 && $urandom_range(0, 9) < 4) v = 0;
            if ($urandom_range(0, 19) == 0) s = {s, 8'($urandom_range(0, 255))};
            else if (v < 10) s = {s, 8'(8'h30 + v)};
            else if ($urandom_range(0, 1)) s = {s, 8'(8'h61 + v - 10)};
            else s = {s, 8'(8'h41 + v - 10)};
          end
        end else begin
          // string ends on a lone backslash or inside a unicode escape
          s = {s, jsu_pkg::CH_BSLASH};
          if ($urandom_range(0, 1)) begin
            s = {s, jsu_pkg::CH_U};
            repeat ($urandom_range(0, 2)) s = {s, 8'($urandom_range(8'h30, 8'h7A))};
          end
          break;
        end
      end
      send_string(s);
      if (!paused && raw_sent - random_sent >= 250) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: json_string_unescape_unit.f
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_decode.sv
hw/rtl/json_string_unescape_unit.sv
tb/jsu_decode_checker.sv
tb/tb_json_string_unescape_unit.sv
